// File: src/mavg_pkg.sv
package mavg_pkg;

	// Fixed field widths
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned WIN_W    = 6;

	// Window length after reset (clamped to the ring depth)
	localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(20);

	// Divider status seen by the controller
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// File: src/moving_average_filter.sv
// Moving average filter.
// Input channel (sample, in_valid, in_ready) takes one 16-bit sample per
// transaction; output channel (average, out_valid, out_ready) returns one
// 16-bit truncated mean per sample, in order.
// Writing cfg_data with cfg_we sets the window length (0 counts as 1, values
// above MAX_WINDOW count as MAX_WINDOW) and clears history, sum and count;
// write only while no sample is in flight.
// Samples sit in a one-read, one-write RAM. A sample is read-modify-written
// (old entry read, sum updated, new entry written), then the sum is divided
// by the sample count in a one-bit-per-cycle restoring divider.
// One sample is in work at a time: the next sample is accepted only after
// the result of the last one has been loaded into the output register.
// Reset: window length 20, history empty; the first results average fewer
// samples until the window fills. No RAM clearing pass: entries not yet
// written since the last clear are read as zero by the fill count.
// A finished result waits in the output register while the next sample is
// accepted; if out_ready stays low the filter stalls before loading the
// following result.
module moving_average_filter #(
	parameter int unsigned MAX_WINDOW = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mavg_pkg::WIN_W-1:0]     cfg_data,
	input  logic [mavg_pkg::SAMPLE_W-1:0]  sample,
	input  logic                           in_valid,
	output logic                           in_ready,
	output logic [mavg_pkg::SAMPLE_W-1:0]  average,
	output logic                           out_valid,
	input  logic                           out_ready
);

	import mavg_pkg::*;

	localparam int unsigned AW    = $clog2(MAX_WINDOW);
	localparam int unsigned SUM_W = SAMPLE_W + $clog2(MAX_WINDOW);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPD,
		ST_DIV,
		ST_OUT
	} state_t;

	function automatic logic [WIN_W-1:0] clamp_win(input logic [WIN_W-1:0] v);
		logic [WIN_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = WIN_W'(1);
		end else if (32'(v) > MAX_WINDOW) begin
			r = WIN_W'(MAX_WINDOW);
		end
		return r;
	endfunction

	state_t            state_q;
	logic [WIN_W-1:0]  win_q;
	logic [WIN_W-1:0]  cnt_q;
	logic [AW-1:0]     pos_q;
	logic [SUM_W-1:0]  sum_q;
	logic [SAMPLE_W-1:0] sample_s1;
	logic [SAMPLE_W-1:0] average_q;
	logic              out_valid_q;

	logic [SAMPLE_W-1:0] ram_rdata;
	logic [SAMPLE_W-1:0] old_val;
	logic [SUM_W-1:0]  sum_next;
	logic [AW:0]       pos_inc;
	logic [AW-1:0]     pos_next;
	logic              warm;
	logic [WIN_W-1:0]  cnt_next;
	logic              ram_we;
	logic              div_start;
	logic [SUM_W-1:0]  quotient;
	div_stat_t         div_stat;
	logic              in_acc;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;

	// Read-modify-write of the ring slot; slots past the fill count read as zero
	always_comb begin
		warm      = (cnt_q < win_q);
		old_val   = warm ? '0 : ram_rdata;
		sum_next  = sum_q - SUM_W'(old_val) + SUM_W'(sample_s1);
		pos_inc   = (AW+1)'(pos_q) + (AW+1)'(1);
		pos_next  = (32'(pos_inc) >= 32'(win_q)) ? '0 : pos_inc[AW-1:0];
		cnt_next  = warm ? cnt_q + WIN_W'(1) : cnt_q;
		ram_we    = (state_q == ST_UPD);
		div_start = (state_q == ST_UPD);
	end

	mavg_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (MAX_WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (pos_q),
		.wdata (sample_s1),
		.raddr (pos_q),
		.rdata (ram_rdata)
	);

	mavg_div #(
		.NUM_W (SUM_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_next),
		.divisor  (cnt_next),
		.quotient (quotient),
		.stat     (div_stat)
	);

	// Sequencer, filter state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			win_q       <= clamp_win(WINDOW_RESET);
			cnt_q       <= '0;
			pos_q       <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Output valid: set when a result loads, cleared when taken
			if (state_q == ST_OUT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				win_q <= clamp_win(cfg_data);
				cnt_q <= '0;
				pos_q <= '0;
				sum_q <= '0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					sum_q   <= sum_next;
					pos_q   <= pos_next;
					cnt_q   <= cnt_next;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			sample_s1 <= sample;
		end
		if (state_q == ST_OUT && (!out_valid_q || out_ready)) begin
			average_q <= quotient[SAMPLE_W-1:0];
		end
	end

	assign average   = average_q;
	assign out_valid = out_valid_q;

endmodule

// File: src/mavg_ram.sv
module mavg_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: src/mavg_div.sv
module mavg_div #(
	parameter int unsigned NUM_W = 21
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [NUM_W-1:0]       dividend,
	input  logic [mavg_pkg::WIN_W-1:0] divisor,
	output logic [NUM_W-1:0]       quotient,
	output mavg_pkg::div_stat_t    stat
);

	import mavg_pkg::*;

	localparam int unsigned STEP_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0]  quo_q;
	logic [WIN_W-1:0]  rem_q;
	logic [WIN_W-1:0]  dvs_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;

	logic [WIN_W:0]    trial;
	logic              fits;
	logic [WIN_W:0]    diff;

	// Restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		trial = {rem_q, quo_q[NUM_W-1]};
		fits  = (trial >= {1'b0, dvs_q});
		diff  = trial - {1'b0, dvs_q};
	end

	// Control: one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(NUM_W);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], fits};
			rem_q <= fits ? diff[WIN_W-1:0] : trial[WIN_W-1:0];
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// File: src/mavg_chk.sv
module mavg_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic [mavg_pkg::SAMPLE_W-1:0] average,
	input logic                          out_valid,
	input logic                          out_ready
);

	// A pending result stays until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped before transaction");

	// A stalled result keeps its value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(average))
		else $error("average changed while stalled");

	// One sample in work at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while a sample is in work");

	// A new result appears only while a sample is in work
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result produced with no sample in work");

endmodule

bind moving_average_filter mavg_chk u_mavg_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.average   (average),
	.out_valid (out_valid),
	.out_ready (out_ready)
);

// File: tb/tb.sv
module tb;

	import mavg_pkg::*;

	localparam int unsigned MAX_WINDOW   = 32;
	localparam int unsigned RESET_CYCLES = 8;
	localparam int unsigned DRAIN_CYCLES = 40;
	localparam int unsigned LONG_HOLD    = 300;
	localparam int unsigned CYCLE_LIMIT  = 1000000;
	localparam int unsigned ITEM_TARGET  = 1200;

	// Sample value mixes for the random phases
	typedef enum int unsigned {
		MIX_UNIFORM,
		MIX_FULL,
		MIX_EDGE
	} sample_mix_t;

	logic                clk;
	logic                arst_n   = 1'b0;
	logic                cfg_we   = 1'b0;
	logic [WIN_W-1:0]    cfg_data = '0;
	logic [SAMPLE_W-1:0] sample   = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [SAMPLE_W-1:0] average;
	logic                out_valid;
	logic                out_ready = 1'b0;

	// Predictor state: window history, running sum, fill count
	logic [SAMPLE_W-1:0] win_hist [MAX_WINDOW];
	int unsigned         win_len_q;
	int unsigned         next_slot;
	int unsigned         fill_count;
	int unsigned         win_sum;

	logic [SAMPLE_W-1:0] sample_pending [$];
	logic [SAMPLE_W-1:0] avg_expected [$];

	int unsigned errors = 0;
	int unsigned cycles = 0;
	int unsigned tx_wait = 0;
	int unsigned rx_wait = 0;
	bit          tx_busy;
	bit          calm = 1'b0;
	bit          hold_req = 1'b0;
	bit          hold_ack = 1'b0;

	moving_average_filter #(
		.MAX_WINDOW(MAX_WINDOW)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.sample   (sample),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.average  (average),
		.out_valid(out_valid),
		.out_ready(out_ready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned clamp_len(input logic [WIN_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_WINDOW)
			return MAX_WINDOW;
		return v;
	endfunction

	function automatic void clear_history();
		foreach (win_hist[i])
			win_hist[i] = '0;
		next_slot  = 0;
		fill_count = 0;
		win_sum    = 0;
	endfunction

	// Replace the oldest entry, update the sum, return the truncated mean
	function automatic logic [SAMPLE_W-1:0] next_average(input logic [SAMPLE_W-1:0] s);
		int unsigned slot;
		slot = next_slot;
		if (slot >= win_len_q)
			slot = 0;
		win_sum = win_sum - win_hist[slot] + s;
		win_hist[slot] = s;
		slot++;
		if (slot >= win_len_q)
			slot = 0;
		next_slot = slot;
		if (fill_count < win_len_q)
			fill_count++;
		return SAMPLE_W'(win_sum / fill_count);
	endfunction

	// Mostly short gaps, a few long ones; none in calm phases
	function automatic int unsigned draw_gap();
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 80)
			return $urandom_range(1, 4);
		if (r < 95)
			return $urandom_range(5, 30);
		return $urandom_range(31, 90);
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_sample(input sample_mix_t mix);
		int unsigned r;
		r = $urandom_range(0, 9);
		case (mix)
			MIX_FULL: begin
				return (r < 8) ? '1 : SAMPLE_W'($urandom);
			end
			MIX_EDGE: begin
				if (r < 3)
					return '0;
				if (r < 6)
					return '1;
				if (r < 8)
					return SAMPLE_W'($urandom_range(0, 15));
				return SAMPLE_W'($urandom);
			end
			default: begin
				return SAMPLE_W'($urandom);
			end
		endcase
	endfunction

	task automatic wait_idle();
		while (sample_pending.size() != 0 || in_valid || avg_expected.size() != 0)
			@(posedge clk);
	endtask

	// Window write: only once everything has drained
	task automatic write_window(input logic [WIN_W-1:0] v);
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_data <= v;
		cfg_we   <= 1'b1;
		win_len_q = clamp_len(v);
		clear_history();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Driver: offer pending samples, predict on each accepted transaction
	always @(posedge clk) begin
		if (arst_n) begin
			tx_busy = in_valid;
			if (in_valid && in_ready) begin
				avg_expected.push_back(next_average(sample));
				tx_busy = 1'b0;
			end
			if (!tx_busy) begin
				if (tx_wait > 0) begin
					tx_wait--;
					in_valid <= 1'b0;
				end else if (sample_pending.size() != 0) begin
					sample   <= sample_pending.pop_front();
					in_valid <= 1'b1;
					tx_wait = draw_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each result with the oldest prediction, pace out_ready
	always @(posedge clk) begin
		logic [SAMPLE_W-1:0] want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (avg_expected.size() == 0) begin
					$display("%0t: unexpected average, expected none, got %0d",
						$time, average);
					errors++;
				end else begin
					want = avg_expected.pop_front();
					if (average !== want) begin
						$display("%0t: average mismatch, expected %0d, got %0d",
							$time, want, average);
						errors++;
					end
				end
				rx_wait = draw_gap();
			end
			// long hold-off so the filter backs up into its input
			if (hold_req != hold_ack) begin
				hold_ack = hold_req;
				rx_wait  = LONG_HOLD;
			end
			if (rx_wait > 0) begin
				rx_wait--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Stimulus sequence
	initial begin
		int unsigned total;
		int unsigned phase;
		int unsigned n;
		logic [WIN_W-1:0] w;
		sample_mix_t mix;

		win_len_q = clamp_len(WINDOW_RESET);
		clear_history();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// window after reset, warm-up with extremes
		sample_pending.push_back(16'd0);
		sample_pending.push_back(16'hFFFF);
		sample_pending.push_back(16'hFFFF);
		sample_pending.push_back(16'd1);
		sample_pending.push_back(16'h8000);

		// zero window is taken as one
		write_window('0);
		sample_pending.push_back(16'hFFFF);
		sample_pending.push_back(16'd0);
		sample_pending.push_back(16'd7);

		// oversized window is clamped to the ring depth
		write_window('1);
		repeat (4) sample_pending.push_back(16'hFFFF);

		// two-entry window, wraps quickly
		write_window(WIN_W'(2));
		sample_pending.push_back(16'hFFFF);
		sample_pending.push_back(16'hFFFE);
		sample_pending.push_back(16'd1);
		sample_pending.push_back(16'd0);
		sample_pending.push_back(16'd3);

		// full window of maximum samples: largest possible sum
		write_window(WIN_W'(MAX_WINDOW));
		total = 40;
		repeat (total) sample_pending.push_back(16'hFFFF);

		// random phases, each with a new window setting
		phase = 0;
		while (total < ITEM_TARGET) begin
			case (phase % 6)
				0:       w = WIN_W'(1);
				1:       w = WIN_W'(MAX_WINDOW);
				2:       w = '0;
				3:       w = '1;
				default: w = WIN_W'($urandom_range(0, 63));
			endcase
			write_window(w);
			calm = ($urandom_range(0, 4) == 0);
			mix  = sample_mix_t'($urandom_range(0, 2));
			n    = $urandom_range(20, 100);
			for (int i = 0; i < n; i++)
				sample_pending.push_back(pick_sample(mix));
			if (phase == 3 || phase == 9)
				hold_req = !hold_req;
			total += n;
			phase++;
		end

		wait_idle();
		calm = 1'b0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && avg_expected.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
